// ===== rtl/core/gwcs_pkg.sv =====
// shared types, widths and register codes for the gated window current sense block
package gwcs_pkg;

	// fixed field widths
	localparam int CH_W      = 2;
	localparam int SMP_W     = 12;
	localparam int THR_W     = 12;
	localparam int MINS_W    = 8;
	localparam int UA_W      = 24;
	localparam int MV_W      = 13;
	localparam int MASK_W    = 4;
	localparam int OCNT_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;

	// full scale is 4096 counts, so scaling divides by a shift of 12
	localparam int FS_SHIFT = 12;

	// operand width of the shared multiply/divide unit, one bit per step
	localparam int OPW = 24;

	// stream widths
	localparam int S_FIELDS_W = CH_W + SMP_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = CH_W + OCNT_W + MV_W + UA_W + MV_W + MV_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// parameter defaults
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int MAX_WINDOW_DEF   = 128;

	// register reset values
	localparam logic [THR_W-1:0]  GATE_THRESHOLD_RST = THR_W'(327);
	localparam logic [MINS_W-1:0] MIN_SAMPLES_RST    = MINS_W'(5);
	localparam logic [UA_W-1:0]   UA_FULL_SCALE_RST  = UA_W'(1100000);
	localparam logic [MV_W-1:0]   MV_FULL_SCALE_RST  = MV_W'(3300);
	localparam logic [MASK_W-1:0] CHANNEL_MASK_RST   = MASK_W'(14);
	localparam logic [SMP_W-1:0]  MIN_RST            = {SMP_W{1'b1}};

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_THRESHOLD = 3'd0,
		REG_MIN_SAMPLES    = 3'd1,
		REG_UA_FULL_SCALE  = 3'd2,
		REG_MV_FULL_SCALE  = 3'd3,
		REG_CHANNEL_MASK   = 3'd4
	} gwcs_reg_e;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_PICK,
		S_MUL_MV,
		S_DIV_MV,
		S_MUL_UA,
		S_DIV_UA,
		S_MUL_MIN,
		S_MUL_MAX,
		S_OUT
	} gwcs_state_e;

	// shared unit operations
	typedef enum logic {
		OP_MUL,
		OP_DIV
	} gwcs_op_e;

	// command from the sequencer to the shared unit
	typedef struct packed {
		logic     start;
		gwcs_op_e op;
	} gwcs_cmd_t;

endpackage

// ===== rtl/core/gated_window_current_sense.sv =====
// top level: per-channel gated accumulation and window-end summary sequencer
// an item is accepted in idle and updates its channel in the next cycle, so no new
// item is taken before that update is made; with no window end it returns to idle.
// a window-end item then reports each enabled channel through the shared unit: six
// operations per enabled channel, then a wait until the result item is taken.
// arst_n clears the channel store, the registers to their defaults and the sequencer.
module gated_window_current_sense #(
	parameter int NUM_CHANNELS = gwcs_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_WINDOW   = gwcs_pkg::MAX_WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [gwcs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gwcs_pkg::CFG_W-1:0]     cfg_wdata,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gwcs_pkg::S_TDATA_W-1:0] s_tdata,  // channel, sample, zero pad
	input  logic                           s_tlast,  // window_end
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_channel, samples_counted, mean_mv, current_ua, min_mv, max_mv, zero pad
	output logic [gwcs_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast   // last
);
	import gwcs_pkg::*;

	localparam int NCH  = (NUM_CHANNELS < (1 << CH_W)) ? NUM_CHANNELS : (1 << CH_W);
	localparam int IW   = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int SW   = SMP_W + CW;
	localparam int PW   = SW + OPW;
	localparam int CMPW = (CW > MINS_W) ? CW : MINS_W;
	localparam int RW   = CH_W + 1;

	// configuration registers
	logic [THR_W-1:0]  thr_q;
	logic [MINS_W-1:0] min_smp_q;
	logic [UA_W-1:0]   ua_fs_q;
	logic [MV_W-1:0]   mv_fs_q;
	logic [MASK_W-1:0] mask_q;

	// channel store
	logic [CW-1:0]    cnt_q [NCH];
	logic [SW-1:0]    sum_q [NCH];
	logic [SMP_W-1:0] min_q [NCH];
	logic [SMP_W-1:0] max_q [NCH];

	// input item, report pointer, results
	logic [CH_W-1:0]  ch_q;
	logic [SMP_W-1:0] smp_q;
	logic             wend_q;
	logic [RW-1:0]    rep_q;
	logic             launched_q;
	logic [PW-1:0]    prod_q;
	logic [CH_W-1:0]  out_ch_q;
	logic [OCNT_W-1:0] out_cnt_q;
	logic [MV_W-1:0]  mean_mv_q;
	logic [UA_W-1:0]  ua_q;
	logic [MV_W-1:0]  min_mv_q;
	logic [MV_W-1:0]  max_mv_q;
	logic             last_q;

	gwcs_state_e state_q, state_d;

	gwcs_cmd_t      cmd;
	logic [PW-1:0]  opa;
	logic [OPW-1:0] opb;
	logic           done;
	logic [PW-1:0]  acc;
	logic [OPW-1:0] quo;

	logic [IW-1:0]    rd_idx;
	logic [CW-1:0]    rd_cnt;
	logic [SW-1:0]    rd_sum;
	logic [SMP_W-1:0] rd_min;
	logic [SMP_W-1:0] rd_max;
	logic             ch_ok;
	logic             upd;
	logic             pick_end;
	logic             pick_hit;
	logic             too_few;
	logic             none;
	logic             more;
	logic [MASK_W-1:0] mask_eff;

	// store read port, shared between accumulate and report
	always_comb begin
		rd_idx = (state_q == S_ACC) ? ch_q[IW-1:0] : rep_q[IW-1:0];
		rd_cnt = cnt_q[rd_idx];
		rd_sum = sum_q[rd_idx];
		rd_min = min_q[rd_idx];
		rd_max = max_q[rd_idx];
	end

	// gate and window checks
	always_comb begin
		ch_ok    = ({1'b0, ch_q} < RW'(NCH));
		upd      = ch_ok && (smp_q > thr_q) && (rd_cnt < CW'(MAX_WINDOW));
		too_few  = (CMPW'(rd_cnt) <= CMPW'(min_smp_q));
		none     = (rd_cnt == '0);
		mask_eff = mask_q & MASK_W'((1 << NCH) - 1);
		pick_end = (rep_q >= RW'(NCH));
		pick_hit = mask_eff[rep_q[CH_W-1:0]];
	end

	// any enabled channel after the one being reported
	always_comb begin
		more = 1'b0;
		for (int i = 0; i < MASK_W; i++) begin
			if (mask_eff[i] && (RW'(i) > rep_q)) begin
				more = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (s_tvalid) state_d = S_ACC;
			S_ACC:     state_d = wend_q ? S_PICK : S_IDLE;
			S_PICK: begin
				if (pick_end) begin
					state_d = S_IDLE;
				end else if (pick_hit) begin
					state_d = S_MUL_MV;
				end
			end
			S_MUL_MV:  if (done) state_d = S_DIV_MV;
			S_DIV_MV:  if (done) state_d = S_MUL_UA;
			S_MUL_UA:  if (done) state_d = S_DIV_UA;
			S_DIV_UA:  if (done) state_d = S_MUL_MIN;
			S_MUL_MIN: if (done) state_d = S_MUL_MAX;
			S_MUL_MAX: if (done) state_d = S_OUT;
			S_OUT:     if (m_tready) state_d = S_PICK;
			default:   state_d = S_IDLE;
		endcase
	end

	// sequencer outputs and shared unit operands
	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		cmd.start = 1'b0;
		cmd.op    = OP_MUL;
		opa       = PW'(rd_sum);
		opb       = OPW'(mv_fs_q);
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_MUL_MV: begin
				cmd.start = !launched_q;
			end
			S_DIV_MV, S_DIV_UA: begin
				cmd.start = !launched_q;
				cmd.op    = OP_DIV;
				opa       = prod_q >> FS_SHIFT;
				opb       = OPW'(rd_cnt);
			end
			S_MUL_UA: begin
				cmd.start = !launched_q;
				opb       = OPW'(ua_fs_q);
			end
			S_MUL_MIN: begin
				cmd.start = !launched_q;
				opa       = PW'(rd_min);
			end
			S_MUL_MAX: begin
				cmd.start = !launched_q;
				opa       = PW'(rd_max);
			end
			S_OUT:  m_tvalid = 1'b1;
			default: begin
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launched_q <= 1'b0;
			rep_q      <= '0;
		end else begin
			state_q <= state_d;
			if (done) begin
				launched_q <= 1'b0;
			end else if (cmd.start) begin
				launched_q <= 1'b1;
			end
			if (state_q == S_ACC) begin
				rep_q <= '0;
			end else if ((state_q == S_PICK) && !pick_end && !pick_hit) begin
				rep_q <= rep_q + RW'(1);
			end else if ((state_q == S_OUT) && m_tready) begin
				rep_q <= rep_q + RW'(1);
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= GATE_THRESHOLD_RST;
			min_smp_q <= MIN_SAMPLES_RST;
			ua_fs_q   <= UA_FULL_SCALE_RST;
			mv_fs_q   <= MV_FULL_SCALE_RST;
			mask_q    <= CHANNEL_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GATE_THRESHOLD: thr_q     <= cfg_wdata[THR_W-1:0];
				REG_MIN_SAMPLES:    min_smp_q <= cfg_wdata[MINS_W-1:0];
				REG_UA_FULL_SCALE:  ua_fs_q   <= cfg_wdata[UA_W-1:0];
				REG_MV_FULL_SCALE:  mv_fs_q   <= cfg_wdata[MV_W-1:0];
				REG_CHANNEL_MASK:   mask_q    <= cfg_wdata[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// channel store: accumulate one item, clear everything after the last report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				cnt_q[c] <= '0;
				sum_q[c] <= '0;
				min_q[c] <= MIN_RST;
				max_q[c] <= '0;
			end
		end else if ((state_q == S_ACC) && upd) begin
			cnt_q[rd_idx] <= rd_cnt + CW'(1);
			sum_q[rd_idx] <= rd_sum + SW'(smp_q);
			if (smp_q < rd_min) min_q[rd_idx] <= smp_q;
			if (smp_q > rd_max) max_q[rd_idx] <= smp_q;
		end else if ((state_q == S_PICK) && pick_end) begin
			for (int c = 0; c < NCH; c++) begin
				cnt_q[c] <= '0;
				sum_q[c] <= '0;
				min_q[c] <= MIN_RST;
				max_q[c] <= '0;
			end
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_q   <= s_tdata[CH_W-1:0];
			smp_q  <= s_tdata[CH_W +: SMP_W];
			wend_q <= s_tlast;
		end
	end

	// result capture from the shared unit
	always_ff @(posedge clk) begin
		if (done) begin
			unique case (state_q)
				S_MUL_MV, S_MUL_UA: prod_q <= acc;
				S_DIV_MV:  mean_mv_q <= too_few ? '0 : quo[MV_W-1:0];
				S_DIV_UA:  ua_q      <= too_few ? '0 : quo[UA_W-1:0];
				S_MUL_MIN: min_mv_q  <= none ? '0 : acc[FS_SHIFT +: MV_W];
				S_MUL_MAX: begin
					max_mv_q  <= none ? '0 : acc[FS_SHIFT +: MV_W];
					out_ch_q  <= rep_q[CH_W-1:0];
					out_cnt_q <= OCNT_W'(rd_cnt);
					last_q    <= !more;
				end
				default: begin
				end
			endcase
		end
	end

	gwcs_muldiv #(
		.PW(PW)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.opa   (opa),
		.opb   (opb),
		.done  (done),
		.acc   (acc),
		.quo   (quo)
	);

	// result item
	assign m_tdata = {{M_PAD_W{1'b0}}, max_mv_q, min_mv_q, ua_q, mean_mv_q, out_cnt_q, out_ch_q};
	assign m_tlast = last_q;

	// no new item is taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	// a result appears only after the last scaling operation of a channel
	a_out_after_max: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_MUL_MAX) && $past(done))
		else $error("result shown before its computation finished");

	// the count of the addressed channel never passes the window limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) && ch_ok |-> rd_cnt <= CW'(MAX_WINDOW))
		else $error("gated count above window limit");

	// the shared unit is started only once per operation
	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("shared unit started twice");

endmodule

// ===== rtl/core/gwcs_muldiv.sv =====
// shared iterative multiply / restoring divide unit built around one adder
module gwcs_muldiv #(
	parameter int PW = 44
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gwcs_pkg::gwcs_cmd_t      cmd,
	input  logic [PW-1:0]            opa,
	input  logic [gwcs_pkg::OPW-1:0] opb,
	output logic                     done,
	output logic [PW-1:0]            acc,
	output logic [gwcs_pkg::OPW-1:0] quo
);
	import gwcs_pkg::*;

	localparam int STEP_W = $clog2(OPW);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(OPW - 1);

	logic              busy_q;
	logic              done_q;
	logic              is_div_q;
	logic [STEP_W-1:0] step_q;
	logic [PW-1:0]     acc_q;
	logic [PW-1:0]     b_q;
	logic [OPW-1:0]    q_q;

	logic [PW:0]   sum;
	logic [PW-1:0] b_in;
	logic          carry;

	// the one adder: add for multiply, subtract with carry-out as no-borrow for divide
	always_comb begin
		b_in  = is_div_q ? ~b_q : b_q;
		sum   = {1'b0, acc_q} + {1'b0, b_in} + {{PW{1'b0}}, is_div_q};
		carry = sum[PW];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			is_div_q <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q   <= 1'b1;
				step_q   <= '0;
				is_div_q <= (cmd.op == OP_DIV);
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand load and one step per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			unique case (cmd.op)
				OP_MUL: begin
					acc_q <= '0;
					b_q   <= opa;
					q_q   <= opb;
				end
				OP_DIV: begin
					acc_q <= opa;
					b_q   <= PW'(opb) << (OPW - 1);
					q_q   <= '0;
				end
				default: begin
					acc_q <= '0;
					b_q   <= '0;
					q_q   <= '0;
				end
			endcase
		end else if (busy_q) begin
			if (is_div_q) begin
				if (carry) begin
					acc_q <= sum[PW-1:0];
				end
				q_q <= {q_q[OPW-2:0], carry};
				b_q <= b_q >> 1;
			end else begin
				if (q_q[0]) begin
					acc_q <= sum[PW-1:0];
				end
				q_q <= q_q >> 1;
				b_q <= b_q << 1;
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
	assign quo  = q_q;

endmodule
